FILE: sv/bezpt_pkg.sv
// ----------------------------------------------------------------------------
// Bezier point and tilt quaternion package
// Shared types, register codes and pipeline stage map.
// ----------------------------------------------------------------------------
`default_nettype none

package bezpt_pkg;

  localparam int PARAM_WIDTH = 16;
  localparam int COORD_WIDTH = 16;
  localparam int QUAT_WIDTH  = 16;

  localparam logic [PARAM_WIDTH:0]  T_ONE   = 17'd65536;
  localparam logic [QUAT_WIDTH-1:0] QUAT_MAX = 16'd32767;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_MID_X = 3'd0,
    REG_MID_Y = 3'd1,
    REG_MID_Z = 3'd2,
    REG_END_X = 3'd3,
    REG_END_Y = 3'd4,
    REG_END_Z = 3'd5
  } reg_idx_t;

  // Pipeline stage map. Each iterative unit resolves one result bit per stage.
  localparam int ST_AB      = 0;    // clamp t, form the two Bernstein weights
  localparam int ST_MUL     = 1;    // weight times control point
  localparam int ST_PT      = 2;    // sum, round and saturate the point
  localparam int ST_SQ      = 3;    // coordinate squares
  localparam int ST_NORM    = 4;    // squared lengths
  localparam int ST_RT_LO   = 5;    // length square roots, 32 bits
  localparam int ST_RT_HI   = 36;
  localparam int ST_PQ      = 37;
  localparam int ST_D1_LO   = 38;   // R2 * 2^32 divided by P or Q, 34 bits
  localparam int ST_D1_HI   = 71;
  localparam int ST_HALF    = 72;
  localparam int ST_D2_LO   = 73;   // half-angle ratios, 32 bits
  localparam int ST_D2_HI   = 104;
  localparam int ST_HRT     = 105;
  localparam int ST_HRT_LO  = 106;  // half-angle square roots, 16 bits
  localparam int ST_HRT_HI  = 121;
  localparam int ST_TMUL    = 122;
  localparam int ST_TDIV    = 123;
  localparam int ST_D3_LO   = 124;  // tilt scaling divisions, 18 bits
  localparam int ST_D3_HI   = 141;
  localparam int ST_OUT     = 142;
  localparam int NUM_STAGES = 143;

  // Everything one word carries down the pipeline.
  typedef struct packed {
    logic [PARAM_WIDTH:0]   t;
    logic [31:0]            a;
    logic [32:0]            b;
    logic [2:0][49:0]       pa;
    logic [2:0][49:0]       pb;
    logic [2:0][15:0]       pt;
    logic [2:0][30:0]       sq;
    logic [31:0]            r2;
    logic [31:0]            ss;
    logic                   deg;
    logic                   negz;
    logic [65:0]            lrem;
    logic [31:0]            lf;
    logic [65:0]            rrem;
    logic [31:0]            rf;
    logic [32:0]            pq;
    logic [65:0]            drem;
    logic [33:0]            dq;
    logic [65:0]            wrem;
    logic [31:0]            wq;
    logic [65:0]            srem;
    logic [31:0]            sq2;
    logic [65:0]            crem;
    logic [15:0]            croot;
    logic [65:0]            erem;
    logic [15:0]            eroot;
    logic [31:0]            mx;
    logic [31:0]            my;
    logic [65:0]            xrem;
    logic [17:0]            xq;
    logic [65:0]            yrem;
    logic [17:0]            yq;
    logic [15:0]            qw;
    logic [15:0]            qx;
    logic [15:0]            qy;
  } ctx_t;

endpackage

`default_nettype wire

FILE: sv/bezier_point_and_tilt_quaternion_top.sv
// ----------------------------------------------------------------------------
// Bezier point and tilt quaternion
// Quadratic Bezier evaluation with a fixed-point tilt quaternion.
// ----------------------------------------------------------------------------
// The block takes one curve parameter word per clock and returns the point
// B(t) = 2t(1-t)*mid + t^2*end of a quadratic Bezier curve that starts at
// the origin, together with the unit quaternion that turns +z onto the
// direction of B. It sustains one word per clock while the output is not
// stalled. The pipeline has 143 register stages, most of them bit-per-stage
// units: two 32-bit square roots run side by side, then a 34-bit divider,
// two 32-bit dividers, two 16-bit square roots and two 18-bit dividers, with
// a few arithmetic stages in between. All stages advance together; a stall
// at the output holds the whole pipeline, so no word is lost or repeated.
// Control points are to be written through the cfg port while the pipeline
// is empty, which the block does not enforce; an index above five is ignored.
`default_nettype none

module bezier_point_and_tilt_quaternion_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [16:0] in_param_t,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_point_x,
  output logic [15:0] out_point_y,
  output logic [15:0] out_point_z,
  output logic [15:0] out_quat_w,
  output logic [15:0] out_quat_x,
  output logic [15:0] out_quat_y,
  output logic [15:0] out_quat_z,
  output logic        out_degenerate
);

  localparam int NS = bezpt_pkg::NUM_STAGES;

  // Control point registers, Q8.8.
  logic [5:0][15:0] cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // End point z resets to one, every other register to zero.
      cfg_r <= {16'd256, {5{16'd0}}};
    end else if (cfg_we) begin
      case (cfg_index)
        bezpt_pkg::REG_MID_X: cfg_r[bezpt_pkg::REG_MID_X] <= cfg_wdata;
        bezpt_pkg::REG_MID_Y: cfg_r[bezpt_pkg::REG_MID_Y] <= cfg_wdata;
        bezpt_pkg::REG_MID_Z: cfg_r[bezpt_pkg::REG_MID_Z] <= cfg_wdata;
        bezpt_pkg::REG_END_X: cfg_r[bezpt_pkg::REG_END_X] <= cfg_wdata;
        bezpt_pkg::REG_END_Y: cfg_r[bezpt_pkg::REG_END_Y] <= cfg_wdata;
        bezpt_pkg::REG_END_Z: cfg_r[bezpt_pkg::REG_END_Z] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves when the output register is free or drained.
  logic              adv;
  logic [NS-1:0]     vld_r;
  bezpt_pkg::ctx_t   ctx_r   [NS];
  bezpt_pkg::ctx_t   ctx_nxt [NS];
  bezpt_pkg::ctx_t   src     [NS];
  bezpt_pkg::ctx_t   ctx_in;

  assign adv      = !vld_r[NS-1] || !out_stall;
  assign in_stall = !adv;

  always_comb begin
    ctx_in   = '0;
    ctx_in.t = in_param_t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int n = 0; n < NS; n++) begin
        ctx_r[n] <= ctx_nxt[n];
      end
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign src[k] = ctx_in;
    end else begin : g_rest
      assign src[k] = ctx_r[k-1];
    end

    always_comb begin : stage_logic
      bezpt_pkg::ctx_t   c;
      logic [16:0]        tc;
      logic [33:0]        m;
      logic signed [49:0] pa_s;
      logic signed [49:0] pb_s;
      logic signed [50:0] sum;
      logic signed [50:0] rnd;
      logic signed [31:0] sqv;
      logic [15:0]        mag;
      logic [15:0]        magx;
      logic [15:0]        magy;
      logic [15:0]        qm;
      logic [65:0]        term;
      logic [65:0]        dsh;
      int                 i;
      c    = src[k];
      tc   = '0;
      m    = '0;
      pa_s = '0;
      pb_s = '0;
      sum  = '0;
      rnd  = '0;
      sqv  = '0;
      mag  = '0;
      magx = '0;
      magy = '0;
      qm   = '0;
      term = '0;
      dsh  = '0;
      i    = 0;
      if (k == bezpt_pkg::ST_AB) begin
        tc  = (c.t > bezpt_pkg::T_ONE) ? bezpt_pkg::T_ONE : c.t;
        c.t = tc;
        m   = 34'(tc) * 34'(17'(bezpt_pkg::T_ONE - tc));
        c.a = {m[30:0], 1'b0};
        m   = 34'(tc) * 34'(tc);
        c.b = m[32:0];
      end else if (k == bezpt_pkg::ST_MUL) begin
        for (int j = 0; j < 3; j++) begin
          pa_s    = $signed({1'b0, c.a}) * $signed(cfg_r[j]);
          pb_s    = $signed({1'b0, c.b}) * $signed(cfg_r[3+j]);
          c.pa[j] = pa_s;
          c.pb[j] = pb_s;
        end
      end else if (k == bezpt_pkg::ST_PT) begin
        for (int j = 0; j < 3; j++) begin
          sum = $signed(c.pa[j]) + $signed(c.pb[j]);
          rnd = (sum + (51'sd1 <<< 31)) >>> 32;
          if (rnd > 51'sd32767) begin
            c.pt[j] = 16'h7fff;
          end else if (rnd < -51'sd32768) begin
            c.pt[j] = 16'h8000;
          end else begin
            c.pt[j] = rnd[15:0];
          end
        end
        c.negz = c.pt[2][15];
      end else if (k == bezpt_pkg::ST_SQ) begin
        for (int j = 0; j < 3; j++) begin
          sqv     = $signed(c.pt[j]) * $signed(c.pt[j]);
          c.sq[j] = sqv[30:0];
        end
      end else if (k == bezpt_pkg::ST_NORM) begin
        c.r2   = 32'(c.sq[0]) + 32'(c.sq[1]);
        c.ss   = c.r2 + 32'(c.sq[2]);
        c.deg  = (c.ss == 32'd0);
        c.lrem = {2'b00, c.ss, 32'd0};
        c.rrem = {2'b00, c.r2, 32'd0};
        c.lf   = '0;
        c.rf   = '0;
      end else if (k >= bezpt_pkg::ST_RT_LO && k <= bezpt_pkg::ST_RT_HI) begin
        // One root bit per stage: rem holds n - root^2.
        i    = bezpt_pkg::ST_RT_HI - k;
        term = (66'(c.lf) << (i + 1)) + (66'd1 << (2 * i));
        if (c.lrem >= term) begin
          c.lrem  = c.lrem - term;
          c.lf[i] = 1'b1;
        end
        term = (66'(c.rf) << (i + 1)) + (66'd1 << (2 * i));
        if (c.rrem >= term) begin
          c.rrem  = c.rrem - term;
          c.rf[i] = 1'b1;
        end
      end else if (k == bezpt_pkg::ST_PQ) begin
        // P when the point is on or above the xy plane, Q below it.
        mag    = c.negz ? 16'(-c.pt[2]) : c.pt[2];
        c.pq   = 33'(c.lf) + (33'(mag) << 16);
        c.drem = {2'b00, c.r2, 32'd0};
        c.dq   = '0;
      end else if (k >= bezpt_pkg::ST_D1_LO && k <= bezpt_pkg::ST_D1_HI) begin
        i   = bezpt_pkg::ST_D1_HI - k;
        dsh = 66'(c.pq) << i;
        if (c.drem >= dsh) begin
          c.drem  = c.drem - dsh;
          c.dq[i] = 1'b1;
        end
      end else if (k == bezpt_pkg::ST_HALF) begin
        c.wrem = 66'(c.negz ? c.dq[32:0] : c.pq) << 29;
        c.srem = 66'(c.negz ? c.pq : c.dq[32:0]) << 29;
        c.wq   = '0;
        c.sq2  = '0;
      end else if (k >= bezpt_pkg::ST_D2_LO && k <= bezpt_pkg::ST_D2_HI) begin
        i   = bezpt_pkg::ST_D2_HI - k;
        dsh = 66'(c.lf) << i;
        if (c.wrem >= dsh) begin
          c.wrem  = c.wrem - dsh;
          c.wq[i] = 1'b1;
        end
        if (c.srem >= dsh) begin
          c.srem   = c.srem - dsh;
          c.sq2[i] = 1'b1;
        end
      end else if (k == bezpt_pkg::ST_HRT) begin
        c.crem  = 66'(c.wq);
        c.croot = '0;
        c.erem  = 66'(c.sq2);
        c.eroot = '0;
      end else if (k >= bezpt_pkg::ST_HRT_LO && k <= bezpt_pkg::ST_HRT_HI) begin
        i    = bezpt_pkg::ST_HRT_HI - k;
        term = (66'(c.croot) << (i + 1)) + (66'd1 << (2 * i));
        if (c.crem >= term) begin
          c.crem     = c.crem - term;
          c.croot[i] = 1'b1;
        end
        term = (66'(c.eroot) << (i + 1)) + (66'd1 << (2 * i));
        if (c.erem >= term) begin
          c.erem     = c.erem - term;
          c.eroot[i] = 1'b1;
        end
      end else if (k == bezpt_pkg::ST_TMUL) begin
        magx = c.pt[0][15] ? 16'(-c.pt[0]) : c.pt[0];
        magy = c.pt[1][15] ? 16'(-c.pt[1]) : c.pt[1];
        c.mx = 32'(magx) * 32'(c.eroot);
        c.my = 32'(magy) * 32'(c.eroot);
      end else if (k == bezpt_pkg::ST_TDIV) begin
        // Round half up: add half the divisor before dividing.
        c.xrem = (66'(c.mx) << 16) + 66'(c.rf >> 1);
        c.yrem = (66'(c.my) << 16) + 66'(c.rf >> 1);
        c.xq   = '0;
        c.yq   = '0;
      end else if (k >= bezpt_pkg::ST_D3_LO && k <= bezpt_pkg::ST_D3_HI) begin
        i   = bezpt_pkg::ST_D3_HI - k;
        dsh = 66'(c.rf) << i;
        if (c.xrem >= dsh) begin
          c.xrem  = c.xrem - dsh;
          c.xq[i] = 1'b1;
        end
        if (c.yrem >= dsh) begin
          c.yrem  = c.yrem - dsh;
          c.yq[i] = 1'b1;
        end
      end else if (k == bezpt_pkg::ST_OUT) begin
        c.qw = (c.croot > bezpt_pkg::QUAT_MAX) ? bezpt_pkg::QUAT_MAX : c.croot;
        if (c.deg) begin
          c.qw = bezpt_pkg::QUAT_MAX;
          c.qx = '0;
          c.qy = '0;
        end else if (c.rf == 32'd0) begin
          c.qx = '0;
          c.qy = '0;
        end else begin
          // x takes the negated sign of y, y takes the sign of x.
          qm   = (c.yq > 18'(bezpt_pkg::QUAT_MAX)) ? bezpt_pkg::QUAT_MAX : c.yq[15:0];
          c.qx = !c.pt[1][15] ? 16'(-qm) : qm;
          qm   = (c.xq > 18'(bezpt_pkg::QUAT_MAX)) ? bezpt_pkg::QUAT_MAX : c.xq[15:0];
          c.qy = c.pt[0][15] ? 16'(-qm) : qm;
        end
      end
      ctx_nxt[k] = c;
    end
  end

  assign out_valid      = vld_r[NS-1];
  assign out_point_x    = ctx_r[NS-1].pt[0];
  assign out_point_y    = ctx_r[NS-1].pt[1];
  assign out_point_z    = ctx_r[NS-1].pt[2];
  assign out_quat_w     = ctx_r[NS-1].qw;
  assign out_quat_x     = ctx_r[NS-1].qx;
  assign out_quat_y     = ctx_r[NS-1].qy;
  assign out_quat_z     = '0;
  assign out_degenerate = ctx_r[NS-1].deg;

`ifndef SYNTHESIS
  // A zero point always comes out as the identity rotation.
  a_deg_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_quat_w == bezpt_pkg::QUAT_MAX && out_quat_x == 16'd0 && out_quat_y == 16'd0)
    else $error("degenerate word without identity quaternion");

  // A degenerate word has a zero point.
  a_deg_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_point_x == 16'd0 && out_point_y == 16'd0 && out_point_z == 16'd0)
    else $error("degenerate flag on a nonzero point");

  // The input side is held back only by a waiting output word.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without an output stall");

  // A point on the z axis gives no x or y tilt.
  a_axis_tilt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_point_x == 16'd0 && out_point_y == 16'd0 |->
      out_quat_x == 16'd0 && out_quat_y == 16'd0)
    else $error("tilt on a point on the z axis");
`endif

endmodule

`default_nettype wire
